[hdl/tnse_pkg.sv]
// Package for the text normalizer with space escape.
// Holds the stream types, the byte constants and the escape lookup.
// No dependencies.
package tnse_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        logic       out_last;
    } out_item_t;

    // One character (or end of text) handed from the front to the back.
    typedef struct packed {
        logic       is_end;
        logic       last_step;
        logic [7:0] ch;
    } tok_t;

    localparam int LIST_DEPTH = 4;
    localparam int LIST_CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] BYTE_EF    = 8'hEF;
    localparam logic [7:0] BYTE_BC    = 8'hBC;
    localparam logic [7:0] BYTE_BD    = 8'hBD;
    localparam logic [7:0] BYTE_80    = 8'h80;
    localparam logic [7:0] BYTE_81    = 8'h81;
    localparam logic [7:0] BYTE_BF    = 8'hBF;
    localparam logic [7:0] BYTE_9E    = 8'h9E;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] OFS_BC     = 8'h60;
    localparam logic [7:0] OFS_BD     = 8'h20;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    localparam logic [1:0] ESC_LEN = 2'd3;

    function automatic logic [7:0] esc_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hE2;
            2'd1:    b = 8'h96;
            default: b = 8'h81;
        endcase
        return b;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == BYTE_SPACE) || ((c >= BYTE_TAB) && (c <= BYTE_CR));
    endfunction

endpackage

[hdl/tnse_front.sv]
// Front end: accepts raw bytes, resolves fullwidth EF sequences and
// pushes a list of characters plus an end token. Uses tnse_pkg.
module tnse_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  tnse_pkg::in_item_t  byte_item,
    output logic                push,
    output tnse_pkg::tok_t      push_tok,
    input  logic                fifo_full
);

    logic [1:0]                      hc_reg, hc_next;
    logic                            sec_bd_reg, sec_bd_next;
    tnse_pkg::tok_t [tnse_pkg::LIST_DEPTH-1:0] lst_reg, lst_next, new_lst;
    logic [tnse_pkg::LIST_CNT_W-1:0] cnt_reg, cnt_next, new_cnt;
    logic                            acc;
    logic                            do_fresh;
    logic [7:0]                      b;
    logic [7:0]                      sec_byte;
    logic                            last;

    assign b        = byte_item.in_byte;
    assign last     = byte_item.in_last;
    assign sec_byte = {7'b1011110, sec_bd_reg};

    assign byte_stall = (cnt_reg > tnse_pkg::LIST_CNT_W'(1))
                     || ((cnt_reg == tnse_pkg::LIST_CNT_W'(1)) && fifo_full);
    assign acc        = byte_valid && !byte_stall;
    assign push       = (cnt_reg != '0) && !fifo_full;
    assign push_tok   = lst_reg[0];

    always_comb
    begin
        new_lst     = '0;
        new_cnt     = '0;
        hc_next     = hc_reg;
        sec_bd_next = sec_bd_reg;
        do_fresh    = 1'b0;
        case (hc_reg)
            tnse_pkg::HELD_ONE:
            begin
                if ((b == tnse_pkg::BYTE_BC) || (b == tnse_pkg::BYTE_BD))
                begin
                    hc_next     = tnse_pkg::HELD_TWO;
                    sec_bd_next = b[0];
                end
                else
                begin
                    new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: last,
                                              ch: tnse_pkg::BYTE_EF};
                    new_cnt  = new_cnt + 1'b1;
                    do_fresh = 1'b1;
                end
            end
            tnse_pkg::HELD_TWO:
            begin
                hc_next = tnse_pkg::HELD_NONE;
                if (!sec_bd_reg && (b >= tnse_pkg::BYTE_81) && (b <= tnse_pkg::BYTE_BF))
                begin
                    new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: last,
                                              ch: b - tnse_pkg::OFS_BC};
                    new_cnt = new_cnt + 1'b1;
                end
                else if (sec_bd_reg && (b >= tnse_pkg::BYTE_80)
                         && (b <= tnse_pkg::BYTE_9E))
                begin
                    new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: last,
                                              ch: b - tnse_pkg::OFS_BD};
                    new_cnt = new_cnt + 1'b1;
                end
                else
                begin
                    new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: last,
                                              ch: tnse_pkg::BYTE_EF};
                    new_cnt = new_cnt + 1'b1;
                    new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: last,
                                              ch: sec_byte};
                    new_cnt  = new_cnt + 1'b1;
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh)
        begin
            if (b == tnse_pkg::BYTE_EF)
            begin
                hc_next = tnse_pkg::HELD_ONE;
            end
            else
            begin
                hc_next = tnse_pkg::HELD_NONE;
                new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: last, ch: b};
                new_cnt = new_cnt + 1'b1;
            end
        end

        if (last)
        begin
            if (hc_next != tnse_pkg::HELD_NONE)
            begin
                new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: 1'b1,
                                          ch: tnse_pkg::BYTE_EF};
                new_cnt = new_cnt + 1'b1;
            end
            if (hc_next == tnse_pkg::HELD_TWO)
            begin
                new_lst[new_cnt[1:0]] = '{is_end: 1'b0, last_step: 1'b1,
                                          ch: {7'b1011110, sec_bd_next}};
                new_cnt = new_cnt + 1'b1;
            end
            new_lst[new_cnt[1:0]] = '{is_end: 1'b1, last_step: 1'b1, ch: 8'h00};
            new_cnt = new_cnt + 1'b1;
            hc_next = tnse_pkg::HELD_NONE;
        end
    end

    always_comb
    begin
        lst_next = lst_reg;
        cnt_next = cnt_reg;
        if (acc)
        begin
            lst_next = new_lst;
            cnt_next = new_cnt;
        end
        else if (push)
        begin
            lst_next = {tnse_pkg::tok_t'('0), lst_reg[tnse_pkg::LIST_DEPTH-1:1]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg     <= tnse_pkg::HELD_NONE;
            sec_bd_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (acc)
            begin
                hc_reg     <= hc_next;
                sec_bd_reg <= sec_bd_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lst_reg <= lst_next;
    end

`ifndef SYNTHESIS
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= tnse_pkg::LIST_CNT_W'(tnse_pkg::LIST_DEPTH)) && (hc_reg != 2'd3))
        else $error("front list count or held count out of range");
`endif

endmodule

[hdl/tnse_fifo.sv]
// Small register queue of character tokens between front and back.
// Uses tnse_pkg.
module tnse_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tnse_pkg::tok_t push_tok,
    output logic           full,
    input  logic           pop,
    output tnse_pkg::tok_t head,
    output logic           head_valid
);

    tnse_pkg::tok_t                  mem_reg [tnse_pkg::FIFO_DEPTH];
    logic [tnse_pkg::FIFO_PTR_W-1:0] wr_reg, rd_reg;
    logic [tnse_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == tnse_pkg::FIFO_CNT_W'(tnse_pkg::FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_tok;
        end
    end

`ifndef SYNTHESIS
    a_fifo_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop || head_valid) && (!push || !full))
        else $error("token queue overflow or underflow");
`endif

endmodule

[hdl/tnse_back.sv]
// Back end: applies space collapsing and escape insertion, holds one byte
// of lookahead to place the end mark, and drives the output register. Uses tnse_pkg.
module tnse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tnse_pkg::tok_t      tok,
    input  logic                tok_valid,
    output logic                pop,
    output logic                norm_valid,
    input  logic                norm_stall,
    output tnse_pkg::out_item_t norm_item
);

    logic                started_reg, started_next;
    logic                pending_reg, pending_next;
    logic [1:0]          esc_reg, esc_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [7:0]          hold_byte_reg, hold_byte_next;
    logic                hold_last_reg, hold_last_next;
    logic                out_valid_reg, out_valid_next;
    tnse_pkg::out_item_t out_reg, out_next;
    logic                out_load;
    logic                load;
    tnse_pkg::out_item_t load_val;
    logic                prod;
    logic [7:0]          prod_byte;
    logic                need_esc;

    assign norm_valid = out_valid_reg;
    assign norm_item  = out_reg;
    assign out_load   = !out_valid_reg || !norm_stall;
    assign need_esc   = !started_reg || pending_reg;

    always_comb
    begin
        started_next    = started_reg;
        pending_next    = pending_reg;
        esc_next        = esc_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_last_next  = hold_last_reg;
        pop             = 1'b0;
        load            = 1'b0;
        load_val        = '0;
        prod            = 1'b0;
        prod_byte       = tok.ch;

        if (tok_valid)
        begin
            if (tok.is_end)
            begin
                if (out_load)
                begin
                    load = 1'b1;
                    if (hold_valid_reg)
                    begin
                        load_val        = '{out_byte: hold_byte_reg, out_has_byte: 1'b1,
                                            out_last: hold_last_reg};
                        hold_valid_next = 1'b0;
                        if (hold_last_reg)
                        begin
                            pop          = 1'b1;
                            started_next = 1'b0;
                            pending_next = 1'b0;
                        end
                    end
                    else
                    begin
                        load_val     = '{out_byte: 8'h00, out_has_byte: 1'b0,
                                         out_last: 1'b1};
                        pop          = 1'b1;
                        started_next = 1'b0;
                        pending_next = 1'b0;
                    end
                end
            end
            else if (tnse_pkg::is_space(tok.ch))
            begin
                pop = 1'b1;
                if (started_reg)
                begin
                    pending_next = 1'b1;
                end
            end
            else if (!hold_valid_reg || out_load)
            begin
                prod = 1'b1;
                if (need_esc && (esc_reg != tnse_pkg::ESC_LEN))
                begin
                    prod_byte = tnse_pkg::esc_byte(esc_reg);
                    esc_next  = esc_reg + 1'b1;
                end
                else
                begin
                    esc_next     = '0;
                    pop          = 1'b1;
                    started_next = 1'b1;
                    pending_next = 1'b0;
                end
            end
        end

        if (prod)
        begin
            if (hold_valid_reg)
            begin
                load     = 1'b1;
                load_val = '{out_byte: hold_byte_reg, out_has_byte: 1'b1, out_last: 1'b0};
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = prod_byte;
            hold_last_next  = tok.last_step;
        end

        out_valid_next = out_load ? load : out_valid_reg;
        out_next       = load ? load_val : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            esc_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            started_reg    <= started_next;
            pending_reg    <= pending_next;
            esc_reg        <= esc_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        hold_last_reg <= hold_last_next;
        out_reg       <= out_next;
    end

`ifndef SYNTHESIS
    a_esc_has_tok: assert property (@(posedge clk) disable iff (!rst_n)
        (esc_reg != 2'd0) |-> (tok_valid && !tok.is_end))
        else $error("escape in progress without a character token");

    a_pending_started: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> started_reg)
        else $error("space pending before text started");

    a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && tok_valid && tok.is_end) |=>
            (out_valid_reg && out_reg.out_last && !started_reg && !hold_valid_reg))
        else $error("end of text did not produce a final result");
`endif

endmodule

[hdl/text_normalizer_space_escape.sv]
// Text normalizer with space escape: NFKC-lite byte stream to escaped stream.
// A byte waits in a one-byte lookahead until the next output byte or the end of
// text is known. Throughput: one output byte per cycle from the back end while
// norm_stall is low; one input byte per cycle while each byte yields one token
// and the queue has room; extra tokens (end of text, failed EF sequence) and
// inserted escapes can stall the input. Reset: rst_n async, active low.
module text_normalizer_space_escape (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  tnse_pkg::in_item_t  byte_item,
    output logic                norm_valid,
    input  logic                norm_stall,
    output tnse_pkg::out_item_t norm_item
);

    logic           push;
    tnse_pkg::tok_t push_tok;
    logic           fifo_full;
    logic           pop;
    tnse_pkg::tok_t head;
    logic           head_valid;

    tnse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .push       (push),
        .push_tok   (push_tok),
        .fifo_full  (fifo_full)
    );

    tnse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_tok   (push_tok),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    tnse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok        (head),
        .tok_valid  (head_valid),
        .pop        (pop),
        .norm_valid (norm_valid),
        .norm_stall (norm_stall),
        .norm_item  (norm_item)
    );

endmodule
